### rtl/sseq_pkg.sv
// Shared types, constants and coil tables for the stepper step sequencer.
`default_nettype none

package sseq_pkg;

    // Widths of the free-running millisecond clock and the step position
    localparam int TIME_WIDTH = 32;
    localparam int POS_WIDTH  = 16;

    // Fixed field widths
    localparam int STEPS_W = 16;
    localparam int DELAY_W = 16;
    localparam int REV_W   = 16;
    localparam int COIL_W  = 4;
    localparam int IDX_W   = 2;
    localparam int WDATA_W = 16;

    // Width of the position compare, wide enough for position + 1 and the wrap count
    localparam int CMP_W = ((POS_WIDTH > REV_W) ? POS_WIDTH : REV_W) + 1;

    // Packed result width and its byte-aligned stream width
    localparam int RES_BITS  = COIL_W + POS_WIDTH + STEPS_W + 1 + 1;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Item kinds
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Wiring modes
    localparam logic WIRE_TWO  = 1'b0;
    localparam logic WIRE_FOUR = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_STEP_DELAY = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEPS_REV  = 2'd1;
    localparam logic [IDX_W-1:0] REG_WIRING     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd10;
    localparam logic [REV_W-1:0]   STEPS_REV_RST  = 16'd200;
    localparam logic               WIRING_RST     = WIRE_FOUR;

    typedef struct packed {
        logic [DELAY_W-1:0] step_delay_ms;
        logic [REV_W-1:0]   steps_per_rev;
        logic               wiring_mode;
    } sseq_cfg_t;

    typedef struct packed {
        logic               op;
        logic [STEPS_W-1:0] move_steps;
    } sseq_item_t;

    typedef struct packed {
        logic                 stepped;
        logic                 busy_res;
        logic [STEPS_W-1:0]   steps_remaining;
        logic [POS_WIDTH-1:0] position;
        logic [COIL_W-1:0]    coil_pattern;
    } sseq_result_t;

    // Full-step coil sequence, selected by position mod 4
    function automatic logic [COIL_W-1:0] coil_lookup(input logic mode, input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        pat = '0;
        if (mode == WIRE_FOUR) begin
            case (phase)
                2'd0:    pat = 4'd5;
                2'd1:    pat = 4'd6;
                2'd2:    pat = 4'd10;
                default: pat = 4'd9;
            endcase
        end else begin
            case (phase)
                2'd0:    pat = 4'd2;
                2'd1:    pat = 4'd3;
                2'd2:    pat = 4'd1;
                default: pat = 4'd0;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/sseq_cfg.sv
// Configuration register file of the stepper step sequencer.
`default_nettype none

module sseq_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sseq_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [sseq_pkg::WDATA_W-1:0]  cfg_wdata,
    output sseq_pkg::sseq_cfg_t                cfg
);

    sseq_pkg::sseq_cfg_t cfg_reg;

    // Decode the write index and update one register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay_ms <= sseq_pkg::STEP_DELAY_RST;
            cfg_reg.steps_per_rev <= sseq_pkg::STEPS_REV_RST;
            cfg_reg.wiring_mode   <= sseq_pkg::WIRING_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sseq_pkg::REG_STEP_DELAY: cfg_reg.step_delay_ms <= cfg_wdata[sseq_pkg::DELAY_W-1:0];
                sseq_pkg::REG_STEPS_REV:  cfg_reg.steps_per_rev <= cfg_wdata[sseq_pkg::REV_W-1:0];
                sseq_pkg::REG_WIRING:     cfg_reg.wiring_mode   <= cfg_wdata[0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/sseq_core.sv
// Motion state and single-pass step logic of the stepper step sequencer.
`default_nettype none

module sseq_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sseq_pkg::sseq_cfg_t   cfg,
    input  wire logic                  fire,
    input  wire sseq_pkg::sseq_item_t  item,
    output sseq_pkg::sseq_result_t     res
);

    localparam int TW = sseq_pkg::TIME_WIDTH;
    localparam int PW = sseq_pkg::POS_WIDTH;
    localparam int SW = sseq_pkg::STEPS_W;
    localparam int CW = sseq_pkg::CMP_W;

    logic [TW-1:0]                  time_reg, time_next;
    logic [TW-1:0]                  last_step_reg, last_step_next;
    logic [PW-1:0]                  pos_reg, pos_next;
    logic [SW-1:0]                  steps_left_reg, steps_left_next;
    logic                           forward_reg, forward_next;
    logic [sseq_pkg::COIL_W-1:0]    coil_reg, coil_next;

    logic [SW-1:0]                  steps_load;
    logic                           fwd_load;
    logic [TW-1:0]                  elapsed;
    logic                           step_go;
    logic [CW-1:0]                  rev_ext;
    logic [CW-1:0]                  pos_ext;
    logic [CW-1:0]                  pos_inc;
    logic [PW-1:0]                  pos_stepped;

    // Apply the item: load a move or advance the clock
    always_comb
    begin
        steps_load = steps_left_reg;
        fwd_load   = forward_reg;
        time_next  = time_reg;
        if (item.op == sseq_pkg::OP_MOVE)
        begin
            if (item.move_steps == '0)
            begin
                steps_load = '0;
            end
            else
            begin
                // Negate as unsigned: the most negative move gives its full magnitude
                steps_load = item.move_steps[SW-1] ? SW'(-item.move_steps) : item.move_steps;
                fwd_load   = !item.move_steps[SW-1];
            end
        end
        else
        begin
            time_next = time_reg + TW'(1);
        end
    end

    // Check step timing with the modular elapsed time
    assign elapsed = time_next - last_step_reg;
    assign step_go = (steps_load != '0) && (elapsed >= TW'(cfg.step_delay_ms));

    // Advance or retreat the position, wrapping at the revolution count
    always_comb
    begin
        rev_ext = (cfg.steps_per_rev == '0) ? CW'(1) : CW'(cfg.steps_per_rev);
        pos_ext = CW'(pos_reg);
        pos_inc = pos_ext + CW'(1);
        if (fwd_load)
        begin
            if (pos_inc >= rev_ext || pos_inc[PW])
                pos_stepped = '0;
            else
                pos_stepped = pos_inc[PW-1:0];
        end
        else
        begin
            if (pos_reg == '0 || pos_ext >= rev_ext)
                pos_stepped = PW'(rev_ext - CW'(1));
            else
                pos_stepped = pos_reg - PW'(1);
        end
    end

    // Select next state for this transfer
    always_comb
    begin
        last_step_next  = last_step_reg;
        pos_next        = pos_reg;
        steps_left_next = steps_load;
        forward_next    = fwd_load;
        coil_next       = coil_reg;
        if (step_go)
        begin
            last_step_next  = time_next;
            pos_next        = pos_stepped;
            steps_left_next = steps_load - SW'(1);
            coil_next       = sseq_pkg::coil_lookup(cfg.wiring_mode, pos_stepped[1:0]);
        end
    end

    // Hold state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            last_step_reg  <= '0;
            pos_reg        <= '0;
            steps_left_reg <= '0;
            forward_reg    <= 1'b1;
            coil_reg       <= '0;
        end
        else if (fire)
        begin
            time_reg       <= time_next;
            last_step_reg  <= last_step_next;
            pos_reg        <= pos_next;
            steps_left_reg <= steps_left_next;
            forward_reg    <= forward_next;
            coil_reg       <= coil_next;
        end
    end

    // Result seen after this item
    assign res.coil_pattern    = coil_next;
    assign res.position        = pos_next;
    assign res.steps_remaining = steps_left_next;
    assign res.busy_res        = (steps_left_next != '0);
    assign res.stepped         = step_go;

endmodule

`default_nettype wire

### rtl/stepper_step_sequencer.sv
// Top level of the stepper step sequencer: stream ports, input and result registers.
`default_nettype none

// Full-step stepper sequencer. Each input transfer is either a move (tuser = 0,
// tdata = signed step count, replacing any pending count) or a one-millisecond
// tick (tuser = 1). Every transfer yields exactly one result with the held coil
// pattern, position, remaining steps, busy flag and whether a step was taken.
// One transfer is accepted per clock unless results back up. The input register
// captures the item at its transfer, and the combinational motion logic loads
// the result register when the item fires, once the result register is free or
// being drained, so items flow at one per clock while the results are taken;
// tready drops only while both registers are full and the result is not taken.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_wdata
// and should only change while idle.
module stepper_step_sequencer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [sseq_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [sseq_pkg::WDATA_W-1:0]      cfg_wdata,
    // Input stream
    input  wire logic                              s_tvalid,
    output wire logic                              s_tready,
    input  wire logic [sseq_pkg::STEPS_W-1:0]      s_tdata,   // [15:0] move_steps
    input  wire logic                              s_tuser,   // [0] op
    // Result stream
    output wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [3:0] coil_pattern, [19:4] position, [35:20] steps_remaining,
    // [36] busy_res, [37] stepped, upper bits zero
    output wire logic [sseq_pkg::M_TDATA_W-1:0]    m_tdata
);

    sseq_pkg::sseq_cfg_t    cfg;
    sseq_pkg::sseq_item_t   in_item_reg;
    sseq_pkg::sseq_result_t res;
    sseq_pkg::sseq_result_t out_res_reg;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   fire;
    logic                   in_take;

    sseq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.move_steps <= s_tdata;
        end
    end

    sseq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sseq_pkg::M_TDATA_W'(out_res_reg);

endmodule

`default_nettype wire

### verif/stepper_step_sequencer_test.sv
// Self-checking stream testbench for the stepper step sequencer with a motion predictor.
`timescale 1ns / 1ps

module stepper_step_sequencer_test;

    // Predicts the motion state per input transfer and checks each result transfer
    class motion_predictor;
        logic [sseq_pkg::DELAY_W-1:0]    gap_ms;
        logic [sseq_pkg::REV_W-1:0]      rev_count;
        logic                            wiring;
        logic [sseq_pkg::TIME_WIDTH-1:0] now_ms;
        logic [sseq_pkg::TIME_WIDTH-1:0] last_ms;
        logic [sseq_pkg::POS_WIDTH-1:0]  pos;
        logic [sseq_pkg::STEPS_W-1:0]    left;
        logic                            fwd;
        logic [sseq_pkg::COIL_W-1:0]     coil;
        logic [sseq_pkg::COIL_W-1:0]     two_wire_table[4] = '{4'd2, 4'd3, 4'd1, 4'd0};
        logic [sseq_pkg::COIL_W-1:0]     four_wire_table[4] = '{4'd5, 4'd6, 4'd10, 4'd9};
        sseq_pkg::sseq_result_t          expected_results[$];
        int                              mismatches;

        function new();
            gap_ms     = sseq_pkg::STEP_DELAY_RST;
            rev_count  = sseq_pkg::STEPS_REV_RST;
            wiring     = sseq_pkg::WIRING_RST;
            now_ms     = '0;
            last_ms    = '0;
            pos        = '0;
            left       = '0;
            fwd        = 1'b1;
            coil       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [sseq_pkg::IDX_W-1:0] idx,
                                logic [sseq_pkg::WDATA_W-1:0] value);
            if (idx == sseq_pkg::REG_STEP_DELAY)
                gap_ms = value;
            else if (idx == sseq_pkg::REG_STEPS_REV)
                rev_count = value;
            else if (idx == sseq_pkg::REG_WIRING)
                wiring = value[0];
        endfunction

        // Move one step, wrapping at the revolution count, and latch the coil pattern
        function void take_step();
            logic [sseq_pkg::REV_W:0] rev;
            logic [sseq_pkg::REV_W:0] p;
            rev = (rev_count == 0) ? 17'd1 : {1'b0, rev_count};
            if (fwd)
            begin
                p = {1'b0, pos} + 17'd1;
                if (p >= rev)
                    p = '0;
            end
            else
            begin
                if (pos == 0 || {1'b0, pos} >= rev)
                    p = rev - 17'd1;
                else
                    p = {1'b0, pos} - 17'd1;
            end
            pos     = p[sseq_pkg::POS_WIDTH-1:0];
            last_ms = now_ms;
            left    = left - 1'b1;
            coil    = (wiring == sseq_pkg::WIRE_FOUR) ? four_wire_table[p[1:0]]
                                                      : two_wire_table[p[1:0]];
        endfunction

        function void note_item(logic op, logic [sseq_pkg::STEPS_W-1:0] steps);
            sseq_pkg::sseq_result_t          r;
            logic                            did;
            logic [sseq_pkg::TIME_WIDTH-1:0] elapsed;
            did = 1'b0;
            if (op == sseq_pkg::OP_MOVE)
            begin
                if (steps == 0)
                    left = '0;
                else if (steps[sseq_pkg::STEPS_W-1])
                begin
                    left = -steps;
                    fwd  = 1'b0;
                end
                else
                begin
                    left = steps;
                    fwd  = 1'b1;
                end
            end
            else
                now_ms = now_ms + 1'b1;
            // Step test runs after the item's own effect
            if (left != 0)
            begin
                elapsed = now_ms - last_ms;
                if (elapsed >= {{(sseq_pkg::TIME_WIDTH-sseq_pkg::DELAY_W){1'b0}}, gap_ms})
                begin
                    take_step();
                    did = 1'b1;
                end
            end
            r.coil_pattern    = coil;
            r.position        = pos;
            r.steps_remaining = left;
            r.busy_res        = (left != 0);
            r.stepped         = did;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned exp, longint unsigned act);
            if (exp != act)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(logic [sseq_pkg::M_TDATA_W-1:0] data);
            sseq_pkg::sseq_result_t got;
            sseq_pkg::sseq_result_t exp;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expectation pending: %h", data);
                mismatches++;
                return;
            end
            got = data[sseq_pkg::RES_BITS-1:0];
            exp = expected_results.pop_front();
            compare_field("coil_pattern", exp.coil_pattern, got.coil_pattern);
            compare_field("position", exp.position, got.position);
            compare_field("steps_remaining", exp.steps_remaining, got.steps_remaining);
            compare_field("busy_res", exp.busy_res, got.busy_res);
            compare_field("stepped", exp.stepped, got.stepped);
            compare_field("tdata padding", 0,
                          data[sseq_pkg::M_TDATA_W-1:sseq_pkg::RES_BITS]);
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [sseq_pkg::IDX_W-1:0]       cfg_index;
    logic [sseq_pkg::WDATA_W-1:0]     cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [sseq_pkg::STEPS_W-1:0]     s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sseq_pkg::M_TDATA_W-1:0]   m_tdata;

    motion_predictor tracker = new();
    bit              steady;

    // Phase table: step delay, steps per revolution, wiring, opening move
    int unsigned ph_delay[8] = '{0, 0, 1, 0, 0, 65535, 2, 3};
    int unsigned ph_rev[8]   = '{200, 5, 0, 1, 65535, 3, 12, 7};
    int unsigned ph_wire[8]  = '{1, 0, 1, 0, 1, 0, 1, 0};
    int          ph_lead[8]  = '{20, -3, 5, 4, -2, 6, -9, 15};

    stepper_step_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 125 MHz clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Record accepted inputs and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.note_item(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // Result sink with random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Present one item; returns at the falling edge after its transfer with valid held
    task automatic send_item(logic op, logic [sseq_pkg::STEPS_W-1:0] steps);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = steps;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [sseq_pkg::IDX_W-1:0] idx,
                             logic [sseq_pkg::WDATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_wdata = 16'($urandom);
    endtask

    task automatic configure(int unsigned delay, int unsigned rev, int unsigned wiring_sel);
        logic [sseq_pkg::WDATA_W-1:0] wire_word;
        // Upper bits of the wiring write are don't-care
        wire_word = {15'd0, wiring_sel[0]};
        if ($urandom_range(0, 1))
            wire_word = wire_word | (16'($urandom) & 16'hFFFE);
        write_reg(sseq_pkg::REG_STEP_DELAY, delay[sseq_pkg::DELAY_W-1:0]);
        write_reg(sseq_pkg::REG_STEPS_REV, rev[sseq_pkg::REV_W-1:0]);
        write_reg(sseq_pkg::REG_WIRING, wire_word);
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // Mostly ticks, with short moves in both directions and some full-range moves
    task automatic run_random(int count);
        int          pick;
        int          mag;
        logic [15:0] value;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_item(sseq_pkg::OP_TICK, 16'($urandom));
            else
            begin
                pick = $urandom_range(0, 9);
                mag  = $urandom_range(1, 12);
                if (pick == 0)
                    value = '0;
                else if (pick < 8)
                    value = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                else
                    value = 16'($urandom);
                send_item(sseq_pkg::OP_MOVE, value);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = sseq_pkg::OP_MOVE;
        steady    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, zero move, first step after the delay
        send_item(sseq_pkg::OP_MOVE, 16'd0);
        send_item(sseq_pkg::OP_MOVE, 16'd3);
        repeat (10) send_item(sseq_pkg::OP_TICK, 16'($urandom));
        // Short backward move, both extremes, then a zero move keeping direction
        send_item(sseq_pkg::OP_MOVE, 16'hFFFF);
        send_item(sseq_pkg::OP_MOVE, 16'h7FFF);
        send_item(sseq_pkg::OP_MOVE, 16'h8000);
        send_item(sseq_pkg::OP_MOVE, 16'd0);
        send_item(sseq_pkg::OP_TICK, 16'hFFFF);
        drain();

        // Directed: a single-step move goes forward, and a move steps on its own item
        write_reg(sseq_pkg::REG_STEP_DELAY, 16'd0);
        send_item(sseq_pkg::OP_MOVE, 16'd1);
        send_item(sseq_pkg::OP_MOVE, 16'hFFFF);
        send_item(sseq_pkg::OP_MOVE, 16'hFFFE);
        send_item(sseq_pkg::OP_TICK, 16'h0000);
        drain();

        // Fixed phases covering register extremes and a lowered revolution count
        for (int ph = 0; ph < 8; ph++)
        begin
            configure(ph_delay[ph], ph_rev[ph], ph_wire[ph]);
            send_item(sseq_pkg::OP_MOVE, 16'(ph_lead[ph]));
            run_random(35);
            drain();
        end

        // Random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            configure($urandom_range(0, 3),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 16),
                      $urandom_range(0, 1));
            run_random(20);
            drain();
        end

        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("stepper_step_sequencer test passed");
        else
            $display("stepper_step_sequencer test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("stepper_step_sequencer test failed");
        $finish;
    end

endmodule
